// ===== hw/rtl/tvbs_pkg.sv =====
// shared types and constants for the typed value byte serializer
package tvbs_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 48;
  localparam int unsigned CntW    = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_RAW   = 3'd0,
    FUNC_INT32 = 3'd1,
    FUNC_INT64 = 3'd2,
    FUNC_VAR32 = 3'd3,
    FUNC_VAR64 = 3'd4,
    FUNC_CHAR  = 3'd5
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  localparam logic [ByteW-1:0] VarMask   = 8'h7F;
  localparam logic [ByteW-1:0] ContBit   = 8'h80;
  localparam logic [ByteW-1:0] Utf2Lead  = 8'hC0;
  localparam logic [ByteW-1:0] Utf3Lead  = 8'hE0;
  localparam logic [15:0]      Utf1Max   = 16'h007F;
  localparam logic [15:0]      Utf2Max   = 16'h07FF;

  // sequencer to shift unit
  typedef struct packed {
    logic load;
    logic step;
  } sh_ctrl_t;

  // shift unit to sequencer and output stage
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } sh_stat_t;

endpackage

// ===== hw/rtl/tvbs_if.sv =====
// request and result channel interfaces
interface tvbs_in_if;
  import tvbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [ValueW-1:0] value;
  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface tvbs_out_if;
  import tvbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   data_byte;
  logic               last;
  logic [OffsetW-1:0] byte_offset;
  modport source (output valid, output data_byte, output last, output byte_offset, input ready);
  modport sink (input valid, input data_byte, input last, input byte_offset, output ready);
endinterface

// ===== hw/rtl/typed_value_byte_serializer.sv =====
// top level of the typed value byte serializer
//
//  channel | dir | payload                                | handshake
//  in_i    | in  | func[2:0], value[63:0]                 | valid/ready
//  out_o   | out | data_byte[7:0], last, byte_offset[47:0] | valid/ready
//
// a request is accepted, then yields 1 to 10 bytes from the single shift unit,
// one byte a cycle while the output register is free to take it.
// an unused kind is taken in the accept cycle and yields no byte.
// the output register lets the next request in while the last byte waits.
// a stalled output holds the sequencer in place; nothing is dropped.
// reset clears the stream position and all control state.
module typed_value_byte_serializer
  import tvbs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvbs_in_if.sink    in_i,
  tvbs_out_if.source out_o
);

  logic [POSITION_BITS-1:0]         pos_q, pos_d;
  logic [OffsetW+POSITION_BITS-1:0] pos_ext;
  logic                             out_valid_q, out_valid_d;
  logic [ByteW-1:0]                 out_data_q;
  logic                             out_last_q;
  logic [OffsetW-1:0]               out_off_q;
  logic                             out_free;
  logic                             emit;
  sh_ctrl_t                         sh_ctrl;
  sh_stat_t                         sh_stat;

  assign out_free = !out_valid_q || out_o.ready;
  assign pos_ext  = {{OffsetW{1'b0}}, pos_q};

  tvbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .out_free_i (out_free),
    .last_i     (sh_stat.last),
    .in_ready_o (in_i.ready),
    .emit_o     (emit),
    .ctrl_o     (sh_ctrl)
  );

  tvbs_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sh_ctrl),
    .func_i  (in_i.func),
    .value_i (in_i.value),
    .stat_o  (sh_stat)
  );

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      pos_d       = pos_q + POSITION_BITS'(1);
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= sh_stat.data;
      out_last_q <= sh_stat.last;
      out_off_q  <= pos_ext[OffsetW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_byte   = out_data_q;
  assign out_o.last        = out_last_q;
  assign out_o.byte_offset = out_off_q;

endmodule

// ===== hw/rtl/tvbs_shift.sv =====
// shared shift unit: holds the value and yields one byte per step
module tvbs_shift
  import tvbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sh_ctrl_t          ctrl_i,
  input  logic [FuncW-1:0]  func_i,
  input  logic [ValueW-1:0] value_i,
  output sh_stat_t          stat_o
);

  logic [ValueW-1:0] sh_q, sh_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              vint_q, vint_d;
  logic              more;
  logic [15:0]       code;
  logic [ValueW-1:0] rev64;

  assign code = value_i[15:0];
  assign more = |sh_q[ValueW-1:7];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev64[8*i +: 8] = value_i[8*(7-i) +: 8];
    end
  end

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    vint_d = vint_q;
    if (ctrl_i.load) begin
      sh_d   = '0;
      cnt_d  = '0;
      vint_d = 1'b0;
      unique case (func_i)
        FUNC_RAW: begin
          sh_d[7:0] = value_i[7:0];
        end
        FUNC_INT32: begin
          sh_d[31:0] = {value_i[7:0], value_i[15:8], value_i[23:16], value_i[31:24]};
          cnt_d      = CntW'(3);
        end
        FUNC_INT64: begin
          sh_d  = rev64;
          cnt_d = CntW'(7);
        end
        FUNC_VAR32: begin
          sh_d[31:0] = value_i[31:0];
          vint_d     = 1'b1;
        end
        FUNC_VAR64: begin
          sh_d   = value_i;
          vint_d = 1'b1;
        end
        FUNC_CHAR: begin
          // zero code takes the two-byte form
          if (code != 16'd0 && code <= Utf1Max) begin
            sh_d[7:0] = code[7:0];
          end else if (code <= Utf2Max) begin
            sh_d[15:0] = {ContBit | {2'b00, code[5:0]}, Utf2Lead | {3'b000, code[10:6]}};
            cnt_d      = CntW'(1);
          end else begin
            sh_d[23:0] = {ContBit | {2'b00, code[5:0]},
                          ContBit | {2'b00, code[11:6]},
                          Utf3Lead | {4'b0000, code[15:12]}};
            cnt_d      = CntW'(2);
          end
        end
        default: begin
          sh_d = '0;
        end
      endcase
    end else if (ctrl_i.step) begin
      sh_d  = vint_q ? (sh_q >> 7) : (sh_q >> 8);
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      vint_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      vint_q <= vint_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign stat_o.data = vint_q ? ((sh_q[7:0] & VarMask) | (more ? ContBit : 8'h00))
                              : sh_q[7:0];
  assign stat_o.last = vint_q ? !more : (cnt_q == '0);

endmodule

// ===== hw/rtl/tvbs_seq.sv =====
// sequencer: accepts a request and steps the shift unit once per byte
module tvbs_seq
  import tvbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [FuncW-1:0] func_i,
  input  logic             out_free_i,
  input  logic             last_i,
  output logic             in_ready_o,
  output logic             emit_o,
  output sh_ctrl_t         ctrl_o
);

  state_e state_q, state_d;
  logic   func_ok;

  assign func_ok = (func_i <= FUNC_CHAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    emit_o      = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // unused codes are taken and dropped
        if (in_valid_i && func_ok) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free_i) begin
          emit_o      = 1'b1;
          ctrl_o.step = 1'b1;
          if (last_i) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tvbs_checker.sv =====
// port-level checks for the serializer, bound to the top level
module tvbs_checker
  import tvbs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [FuncW-1:0]   in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ByteW-1:0]   out_data_i,
  input logic               out_last_i,
  input logic [OffsetW-1:0] out_off_i
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_data_i) && $stable(out_last_i) && $stable(out_off_i))
    else $error("stalled result changed");

  // a taken request with a known kind blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i <= FUNC_CHAR) |=> !in_ready_i)
    else $error("request taken while previous one still running");

  // while idle only the final byte of a request may be waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("ready before all bytes were produced");

  // a non-final byte is followed directly by the next offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i ##1 out_valid_i |->
      out_off_i == $past(out_off_i) + OffsetW'(1) || $past(out_off_i) == out_off_i - OffsetW'(1))
    else $error("byte offsets not consecutive");

endmodule

bind typed_value_byte_serializer tvbs_checker u_tvbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data_byte),
  .out_last_i  (out_o.last),
  .out_off_i   (out_o.byte_offset)
);

// ===== bench/tb_top.sv =====
// testbench for the typed value byte serializer: directed and random requests, checked per byte
`timescale 1ns / 1ps

module tb_top;
  import tvbs_pkg::*;

  // func codes the block leaves unused
  localparam logic [FuncW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic               last;
    logic [OffsetW-1:0] byte_offset;
  } out_byte_t;

  logic clk;
  logic rst_n;
  bit   allow_idle;
  int   mismatches;

  out_byte_t          pending_bytes[$];
  logic [OffsetW-1:0] next_offset;

  tvbs_in_if  in_bus ();
  tvbs_out_if out_bus ();

  typed_value_byte_serializer #(
    .POSITION_BITS(48)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // serialize one request into the expected byte stream
  task automatic encode_value(input logic [FuncW-1:0] func, input logic [ValueW-1:0] value);
    logic [ByteW-1:0]  enc[$];
    logic [ValueW-1:0] v;
    logic [15:0]       code;
    out_byte_t         ob;
    code = value[15:0];
    case (func)
      FUNC_RAW: begin
        enc.push_back(value[7:0]);
      end
      FUNC_INT32: begin
        for (int i = 3; i >= 0; i--) enc.push_back(value[8*i +: 8]);
      end
      FUNC_INT64: begin
        for (int i = 7; i >= 0; i--) enc.push_back(value[8*i +: 8]);
      end
      FUNC_VAR32, FUNC_VAR64: begin
        v = (func == FUNC_VAR32) ? {32'b0, value[31:0]} : value;
        while (v[63:7] != '0) begin
          enc.push_back(ContBit | {1'b0, v[6:0]});
          v = v >> 7;
        end
        enc.push_back(v[7:0]);
      end
      FUNC_CHAR: begin
        if (code != 16'h0000 && code <= Utf1Max) begin
          enc.push_back(code[7:0]);
        end else if (code <= Utf2Max) begin
          // code zero lands here as the two byte form
          enc.push_back(Utf2Lead | {3'b0, code[10:6]});
          enc.push_back(ContBit | {2'b0, code[5:0]});
        end else begin
          enc.push_back(Utf3Lead | {4'b0, code[15:12]});
          enc.push_back(ContBit | {2'b0, code[11:6]});
          enc.push_back(ContBit | {2'b0, code[5:0]});
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < enc.size(); i++) begin
      ob.data_byte   = enc[i];
      ob.last        = (i == enc.size() - 1);
      ob.byte_offset = next_offset;
      pending_bytes.push_back(ob);
      next_offset = next_offset + 1'b1;
    end
  endtask

  // drives one request; entered and left at a falling edge
  task automatic send_request(input logic [FuncW-1:0] func, input logic [ValueW-1:0] value);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_bus.func  = func;
    in_bus.value = value;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    encode_value(func, value);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  // result channel back pressure in bursts while idles are allowed, else always ready
  initial begin
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!allow_idle) begin
        stall_left    = 0;
        out_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(1, 9) - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_byte_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte=%02h last=%0b offset=%0h", $time,
                 out_bus.data_byte, out_bus.last, out_bus.byte_offset);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_bus.data_byte !== want.data_byte || out_bus.last !== want.last ||
            out_bus.byte_offset !== want.byte_offset) begin
          $display("%0t: mismatch expected byte=%02h last=%0b offset=%0h", $time,
                   want.data_byte, want.last, want.byte_offset);
          $display("%0t:          actual   byte=%02h last=%0b offset=%0h", $time,
                   out_bus.data_byte, out_bus.last, out_bus.byte_offset);
          mismatches++;
        end
      end
    end
  end

  task automatic test_raw_and_fixed();
    send_request(FUNC_RAW, 64'h0000_0000_0000_0000);
    send_request(FUNC_RAW, 64'hFFFF_FFFF_FFFF_FF5A);
    send_request(FUNC_INT32, 64'h0000_0000_FFFF_FFFF);
    send_request(FUNC_INT32, 64'hDEAD_BEEF_1234_5678);
    send_request(FUNC_INT64, 64'h0000_0000_0000_0000);
    send_request(FUNC_INT64, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_varints();
    send_request(FUNC_VAR32, 64'h0000_0000_0000_0000);
    send_request(FUNC_VAR32, 64'h0000_0000_0000_007F);
    send_request(FUNC_VAR32, 64'h0000_0000_0000_0080);
    send_request(FUNC_VAR32, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FUNC_VAR64, 64'h0000_0000_0000_3FFF);
    send_request(FUNC_VAR64, 64'h8000_0000_0000_0000);
    send_request(FUNC_VAR64, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_chars();
    send_request(FUNC_CHAR, 64'h0000_0000_0000_0000);
    send_request(FUNC_CHAR, 64'h0000_0000_0000_0001);
    send_request(FUNC_CHAR, 64'h0000_0000_0000_007F);
    send_request(FUNC_CHAR, 64'h0000_0000_0000_0080);
    send_request(FUNC_CHAR, 64'hFFFF_FFFF_FFFF_07FF);
    send_request(FUNC_CHAR, 64'h0000_0000_0000_0800);
    send_request(FUNC_CHAR, 64'h0000_0000_0000_FFFF);
  endtask

  // unused codes must not move the offset
  task automatic test_unused_funcs();
    send_request(FUNC_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FUNC_SPARE7, 64'h0000_0000_0000_0041);
    send_request(FUNC_RAW, 64'h0000_0000_0000_00A5);
  endtask

  task automatic test_random(input int count, input bit idle);
    int                sent;
    logic [FuncW-1:0]  func;
    logic [ValueW-1:0] value;
    sent       = 0;
    allow_idle = idle;
    while (sent < count) begin
      if ($urandom_range(0, 15) == 0) begin
        func = ($urandom_range(0, 1) == 0) ? FUNC_SPARE6 : FUNC_SPARE7;
      end else begin
        func = FuncW'($urandom_range(0, 5));
      end
      // shifted values spread varint lengths and char ranges
      value = {$urandom(), $urandom()};
      if ($urandom_range(0, 1) == 0) value = value >> $urandom_range(0, 63);
      send_request(func, value);
      if (func != FUNC_SPARE6 && func != FUNC_SPARE7) sent++;
    end
  endtask

  initial begin
    mismatches   = 0;
    next_offset  = '0;
    allow_idle   = 1'b1;
    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func  = '0;
    in_bus.value = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_raw_and_fixed();
    test_varints();
    test_chars();
    test_unused_funcs();
    test_random(55, 1'b1);
    test_random(40, 1'b0);

    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tvbs_pkg.sv
hw/rtl/tvbs_if.sv
hw/rtl/tvbs_shift.sv
hw/rtl/tvbs_seq.sv
hw/rtl/typed_value_byte_serializer.sv
hw/rtl/tvbs_checker.sv
bench/tb_top.sv
